/* design/scta_pkg.sv */
package scta_pkg;

  localparam int unsigned KeyTableLen = 59;
  localparam logic [7:0] ReleaseBit  = 8'h80;
  localparam logic [7:0] CodeMask    = 8'h7F;
  localparam logic [7:0] ScLShift    = 8'h2A;
  localparam logic [7:0] ScRShift    = 8'h36;
  localparam logic [7:0] ScCaps      = 8'h3A;

  localparam int unsigned CharW = 7;

  // A decoded character on its way to the queue.
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] ch;
  } push_t;

  // What the queue did with one beat.
  typedef struct packed {
    logic pop_ok;
    logic overflow;
    logic avail;
  } fifo_stat_t;

  // Set-1 key table, lower case or upper case; a zero means no character.
  function automatic logic [CharW-1:0] key_char(input logic [5:0] code, input logic upper);
    logic [CharW-1:0] c;
    c = '0;
    case (code)
      6'd1:  c = 7'h1B;
      6'd2:  c = upper ? 7'h21 : 7'h31;
      6'd3:  c = upper ? 7'h40 : 7'h32;
      6'd4:  c = upper ? 7'h23 : 7'h33;
      6'd5:  c = upper ? 7'h24 : 7'h34;
      6'd6:  c = upper ? 7'h25 : 7'h35;
      6'd7:  c = upper ? 7'h5E : 7'h36;
      6'd8:  c = upper ? 7'h26 : 7'h37;
      6'd9:  c = upper ? 7'h2A : 7'h38;
      6'd10: c = upper ? 7'h28 : 7'h39;
      6'd11: c = upper ? 7'h29 : 7'h30;
      6'd12: c = upper ? 7'h5F : 7'h2D;
      6'd13: c = upper ? 7'h2B : 7'h3D;
      6'd14: c = 7'h08;
      6'd15: c = 7'h09;
      6'd16: c = upper ? 7'h51 : 7'h71;
      6'd17: c = upper ? 7'h57 : 7'h77;
      6'd18: c = upper ? 7'h45 : 7'h65;
      6'd19: c = upper ? 7'h52 : 7'h72;
      6'd20: c = upper ? 7'h54 : 7'h74;
      6'd21: c = upper ? 7'h59 : 7'h79;
      6'd22: c = upper ? 7'h55 : 7'h75;
      6'd23: c = upper ? 7'h49 : 7'h69;
      6'd24: c = upper ? 7'h4F : 7'h6F;
      6'd25: c = upper ? 7'h50 : 7'h70;
      6'd26: c = upper ? 7'h7B : 7'h5B;
      6'd27: c = upper ? 7'h7D : 7'h5D;
      6'd28: c = 7'h0A;
      6'd30: c = upper ? 7'h41 : 7'h61;
      6'd31: c = upper ? 7'h53 : 7'h73;
      6'd32: c = upper ? 7'h44 : 7'h64;
      6'd33: c = upper ? 7'h46 : 7'h66;
      6'd34: c = upper ? 7'h47 : 7'h67;
      6'd35: c = upper ? 7'h48 : 7'h68;
      6'd36: c = upper ? 7'h4A : 7'h6A;
      6'd37: c = upper ? 7'h4B : 7'h6B;
      6'd38: c = upper ? 7'h4C : 7'h6C;
      6'd39: c = upper ? 7'h3A : 7'h3B;
      6'd40: c = upper ? 7'h22 : 7'h27;
      6'd41: c = upper ? 7'h7E : 7'h60;
      6'd43: c = upper ? 7'h7C : 7'h5C;
      6'd44: c = upper ? 7'h5A : 7'h7A;
      6'd45: c = upper ? 7'h58 : 7'h78;
      6'd46: c = upper ? 7'h43 : 7'h63;
      6'd47: c = upper ? 7'h56 : 7'h76;
      6'd48: c = upper ? 7'h42 : 7'h62;
      6'd49: c = upper ? 7'h4E : 7'h6E;
      6'd50: c = upper ? 7'h4D : 7'h6D;
      6'd51: c = upper ? 7'h3C : 7'h2C;
      6'd52: c = upper ? 7'h3E : 7'h2E;
      6'd53: c = upper ? 7'h3F : 7'h2F;
      6'd55: c = 7'h2A;
      6'd57: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

/* design/scta_in_if.sv */
interface scta_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] scan_code;

  modport source (output valid, action, scan_code, input ready);
  modport sink   (input valid, action, scan_code, output ready);
endinterface

/* design/scta_out_if.sv */
interface scta_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] read_char;
  logic       read_valid;
  logic       chars_available;
  logic       overflow;

  modport source (output valid, read_char, read_valid, chars_available, overflow,
                  input ready);
  modport sink   (input valid, read_char, read_valid, chars_available, overflow,
                  output ready);
endinterface

/* design/scta_keymap.sv */
module scta_keymap (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 code_en_i,
  input  logic [7:0]           scan_code_i,
  output scta_pkg::push_t      push_o
);

  logic shift_q, shift_d;
  logic caps_q, caps_d;
  logic [7:0] key;
  logic is_shift_key;

  always_comb begin
    key          = scan_code_i & scta_pkg::CodeMask;
    is_shift_key = (key == scta_pkg::ScLShift) || (key == scta_pkg::ScRShift);
    shift_d      = shift_q;
    caps_d       = caps_q;
    push_o       = '0;
    if (code_en_i) begin
      if ((scan_code_i & scta_pkg::ReleaseBit) != '0) begin
        if (is_shift_key) begin
          shift_d = 1'b0;
        end
      end else if (is_shift_key) begin
        shift_d = 1'b1;
      end else if (scan_code_i == scta_pkg::ScCaps) begin
        caps_d = ~caps_q;
      end else if (scan_code_i < 8'(scta_pkg::KeyTableLen)) begin
        push_o.ch    = scta_pkg::key_char(scan_code_i[5:0], shift_q ^ caps_q);
        push_o.valid = (push_o.ch != '0);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

endmodule

/* design/scta_fifo.sv */
module scta_fifo #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  scta_pkg::push_t                   push_i,
  input  logic                              pop_i,
  output scta_pkg::fifo_stat_t              stat_o,
  output logic [scta_pkg::CharW-1:0]        rd_data_o
);

  localparam int unsigned IdxW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(FIFO_DEPTH + 1);

  logic [scta_pkg::CharW-1:0] mem [FIFO_DEPTH];
  logic [scta_pkg::CharW-1:0] rd_data_q;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] count_q, count_d;
  logic full, empty, do_push, do_pop;

  always_comb begin
    full     = (count_q == CntW'(FIFO_DEPTH));
    empty    = (count_q == '0);
    do_push  = push_i.valid && !full;
    do_pop   = pop_i && !empty;
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    count_d  = count_q;
    if (do_push) begin
      wr_idx_d = (wr_idx_q == IdxW'(FIFO_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
      count_d  = count_q + 1'b1;
    end
    if (do_pop) begin
      rd_idx_d = (rd_idx_q == IdxW'(FIFO_DEPTH - 1)) ? '0 : rd_idx_q + 1'b1;
      count_d  = count_q - 1'b1;
    end
    stat_o.pop_ok   = do_pop;
    stat_o.overflow = push_i.valid && full;
    stat_o.avail    = (count_d != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      count_q  <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      count_q  <= count_d;
    end
  end

  // Pushes and pops come from different beats, so a pop only ever reads a
  // slot written at an earlier edge.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_idx_q] <= push_i.ch;
    end
    if (do_pop) begin
      rd_data_q <= mem[rd_idx_q];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* design/scancode_to_ascii_with_fifo.sv */
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while the output is not stalled; the single-port character memory serves
// either the push of a scancode beat or the pop of a read beat in each cycle.
// Reset (rst_ni, asynchronous, active low) clears the queue pointers, the
// fill count, the shift and caps flags and the output stage. The character
// memory is not cleared; only slots already written are ever read.
module scancode_to_ascii_with_fifo #(
  parameter int unsigned FIFO_DEPTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  scta_in_if.sink     in_i,
  scta_out_if.source  out_o
);

  logic                       accept;
  logic                       code_en;
  logic                       pop_req;
  scta_pkg::push_t            push;
  scta_pkg::fifo_stat_t       stat;
  logic [scta_pkg::CharW-1:0] rd_data;

  // Output stage: one register set holding the result of the last beat.
  logic out_valid_q, out_valid_d;
  scta_pkg::fifo_stat_t stat_q;

  // A new beat is taken whenever the output stage is empty or is being
  // drained in this very cycle, so the block streams at full rate.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // Scancode beats go to the key decoder, read beats to the queue.
  assign code_en = accept && !in_i.action;
  assign pop_req = accept && in_i.action;

  scta_keymap u_keymap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .code_en_i   (code_en),
    .scan_code_i (in_i.scan_code),
    .push_o      (push)
  );

  scta_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop_req),
    .stat_o    (stat),
    .rd_data_o (rd_data)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      stat_q      <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        stat_q <= stat;
      end
    end
  end

  // The memory's read register holds the popped character; it only changes
  // on a pop, so it stays put while the output beat is stalled. A beat that
  // popped nothing shows zero.
  assign out_o.valid           = out_valid_q;
  assign out_o.read_char       = stat_q.pop_ok ? rd_data : '0;
  assign out_o.read_valid      = stat_q.pop_ok;
  assign out_o.chars_available = stat_q.avail;
  assign out_o.overflow        = stat_q.overflow;

endmodule

/* sim/tb_scancode_to_ascii_with_fifo.sv */
`timescale 1ns / 100ps

module tb_scancode_to_ascii_with_fifo;

  localparam int FifoDepth    = 256;
  localparam int RandomBeats  = 1350;
  localparam int PhaseLen     = 300;   // input beats per idling phase
  localparam int HoldOffAt    = 150;   // result beats seen before the long hold-off
  localparam int HoldOffLen   = 300;   // cycles of the long hold-off
  localparam int DrainAt      = 900;   // input beats taken before the sender pauses
  localparam int QuietLimit   = 4000;  // cycles with no beat on either side
  localparam int ReportLimit  = 10;

  // What one input beat asks of the block.
  typedef enum logic {
    ActScan = 1'b0,
    ActRead = 1'b1
  } action_e;

  // How the two sides idle during the current phase of the run.
  typedef enum int {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  typedef struct packed {
    action_e    act;
    logic [7:0] code;
  } key_beat_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       rvalid;
    logic       avail;
    logic       ovf;
  } key_result_t;

  // Set-1 key tables; a zero entry means the key gives no character.
  logic [6:0] lower_keys [scta_pkg::KeyTableLen] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
    7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
    7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };
  logic [6:0] upper_keys [scta_pkg::KeyTableLen] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
    7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
    7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00
  };

  logic clk;
  logic rst_n;

  scta_in_if  key_in ();
  scta_out_if key_out ();

  scancode_to_ascii_with_fifo #(
    .FIFO_DEPTH(FifoDepth)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (key_in.sink),
    .out_o (key_out.source)
  );

  // Our own copy of the keyboard state and of the character queue.
  logic [6:0] char_queue [FifoDepth];
  int         pop_slot;
  int         push_slot;
  int         char_count;
  logic       shift_down;
  logic       caps_toggled;

  key_beat_t   key_stream [$];     // beats still to be offered to the block
  key_result_t pending_results [$]; // results owed by the block, oldest first

  key_beat_t   next_beat;
  key_result_t seen_result;
  key_result_t want_result;

  int         beats_taken;
  int         results_seen;
  int         mismatches;
  int         quiet_cycles;
  int         hold_left;
  logic       hold_done;
  logic       drain_done;
  idle_mode_e idle_mode;

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // The run steps through the idling phases as input beats are taken.
  always_comb idle_mode = idle_mode_e'((beats_taken / PhaseLen) % 4);

  function automatic logic chance(input int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  // Works out the result beat that one accepted input beat must produce, and
  // moves the keyboard state and the character queue on accordingly.
  function automatic key_result_t decode_key_beat(input key_beat_t beat);
    key_result_t res;
    logic [6:0]  ch;
    logic [7:0]  key;
    res = '0;
    key = beat.code & scta_pkg::CodeMask;
    if (beat.act == ActRead) begin
      // A read of an empty queue returns nothing and changes nothing.
      if (char_count != 0) begin
        res.ch     = char_queue[pop_slot];
        res.rvalid = 1'b1;
        pop_slot   = (pop_slot + 1) % FifoDepth;
        char_count = char_count - 1;
      end
    end else if ((beat.code & scta_pkg::ReleaseBit) != 8'h00) begin
      // Only the release of a shift key matters; every other release is dropped.
      if (key == scta_pkg::ScLShift || key == scta_pkg::ScRShift) shift_down = 1'b0;
    end else if (beat.code == scta_pkg::ScLShift || beat.code == scta_pkg::ScRShift) begin
      shift_down = 1'b1;
    end else if (beat.code == scta_pkg::ScCaps) begin
      caps_toggled = ~caps_toggled;
    end else if (beat.code < scta_pkg::KeyTableLen) begin
      ch = (shift_down ^ caps_toggled) ? upper_keys[beat.code] : lower_keys[beat.code];
      if (ch != 7'h00) begin
        // A full queue drops the character and flags it rather than wrapping.
        if (char_count >= FifoDepth) begin
          res.ovf = 1'b1;
        end else begin
          char_queue[push_slot] = ch;
          push_slot  = (push_slot + 1) % FifoDepth;
          char_count = char_count + 1;
        end
      end
    end
    res.avail = (char_count != 0);
    return res;
  endfunction

  task automatic add_scan(input logic [7:0] code);
    key_stream.push_back('{act: ActScan, code: code});
  endtask

  task automatic add_read();
    key_stream.push_back('{act: ActRead, code: 8'($urandom_range(0, 255))});
  endtask

  // A run of len keystrokes of plain typing, with shift and caps lock now and
  // then, as a user would produce them.
  task automatic add_typing(input int len);
    logic [7:0] shift_key;
    logic       shifted;
    shifted   = chance(30);
    shift_key = chance(50) ? scta_pkg::ScLShift : scta_pkg::ScRShift;
    if (chance(10)) add_scan(scta_pkg::ScCaps);
    if (shifted) add_scan(shift_key);
    for (int i = 0; i < len; i++) begin
      if (chance(85)) add_scan(8'($urandom_range(0, scta_pkg::KeyTableLen - 1)));
      else add_scan(8'($urandom_range(scta_pkg::KeyTableLen, 127)));
      if (chance(15)) add_scan(8'($urandom_range(0, 127)) | scta_pkg::ReleaseBit);
    end
    if (shifted) add_scan(shift_key | scta_pkg::ReleaseBit);
  endtask

  task automatic build_stimulus();
    int  sel;
    int  len;
    logic flooded;
    // Directed beats: a read of the empty queue, a table entry of zero, lower
    // and upper case by shift and by caps lock, releases that are ignored,
    // codes beyond the table, and the ends of the scancode range.
    add_read();
    add_scan(8'h00);
    add_scan(8'h1E);
    add_scan(scta_pkg::ScLShift);
    add_scan(8'h02);
    add_scan(scta_pkg::ScCaps);
    add_scan(8'h10);
    add_scan(scta_pkg::ScLShift | scta_pkg::ReleaseBit);
    add_scan(8'h10);
    add_scan(scta_pkg::ScCaps | scta_pkg::ReleaseBit);
    add_scan(scta_pkg::ScCaps);
    add_scan(scta_pkg::ScRShift);
    add_scan(8'h39);
    add_scan(scta_pkg::ScRShift | scta_pkg::ReleaseBit);
    add_scan(8'h3B);
    add_scan(8'h7F);
    add_scan(8'h80);
    add_scan(8'hFF);
    add_scan(8'h01);
    add_scan(8'h1C);
    add_scan(8'h37);
    add_read();
    add_read();
    add_read();
    add_read();

    flooded = 1'b0;
    while (key_stream.size() < RandomBeats + 25) begin
      sel = $urandom_range(0, 99);
      if (!flooded && key_stream.size() > 500) begin
        // Type more than the queue can hold so that it fills and drops
        // characters, then read it dry and a little beyond.
        flooded = 1'b1;
        for (int i = 0; i < FifoDepth + 14; i++) add_scan(8'($urandom_range(16, 25)));
        for (int i = 0; i < FifoDepth + 20; i++) add_read();
      end else if (sel < 45) begin
        add_typing($urandom_range(1, 16));
      end else if (sel < 80) begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) add_read();
      end else if (sel < 92) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          key_stream.push_back('{act: action_e'($urandom_range(0, 1)),
                                 code: 8'($urandom_range(0, 255))});
        end
      end else begin
        len = $urandom_range(2, 10);
        for (int i = 0; i < len; i++) begin
          add_scan(8'($urandom_range(0, scta_pkg::KeyTableLen - 1)));
          add_read();
        end
      end
    end
  endtask

  // Driver: records the prediction for each beat the block takes, then offers
  // the next beat from the stream unless this phase calls for a gap.
  always @(posedge clk) begin
    if (rst_n) begin
      if (key_in.valid && key_in.ready) begin
        pending_results.push_back(decode_key_beat('{act: action_e'(key_in.action),
                                                    code: key_in.scan_code}));
        beats_taken <= beats_taken + 1;
      end
      // Once, the sender waits for every owed result before it goes on.
      if (beats_taken >= DrainAt && !drain_done && pending_results.size() == 0) begin
        drain_done <= 1'b1;
      end
      if (!key_in.valid || key_in.ready) begin
        if (key_stream.size() == 0 || (beats_taken >= DrainAt && !drain_done) ||
            (idle_mode == IdleSender && chance(57)) ||
            (idle_mode == IdleBoth && chance(22))) begin
          key_in.valid <= 1'b0;
        end else begin
          next_beat         = key_stream.pop_front();
          key_in.valid     <= 1'b1;
          key_in.action    <= next_beat.act;
          key_in.scan_code <= next_beat.code;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction and decides
  // whether to take a result on the next cycle.
  always @(posedge clk) begin
    if (rst_n) begin
      if (key_out.valid && key_out.ready) begin
        seen_result = '{ch: key_out.read_char, rvalid: key_out.read_valid,
                        avail: key_out.chars_available, ovf: key_out.overflow};
        results_seen <= results_seen + 1;
        if (pending_results.size() == 0) begin
          if (mismatches < ReportLimit) begin
            $display("result beat with nothing owed: ch=%h valid=%b avail=%b ovf=%b",
                     seen_result.ch, seen_result.rvalid, seen_result.avail,
                     seen_result.ovf);
          end
          mismatches <= mismatches + 1;
        end else begin
          want_result = pending_results.pop_front();
          if (seen_result.ch !== want_result.ch || seen_result.rvalid !== want_result.rvalid ||
              seen_result.avail !== want_result.avail || seen_result.ovf !== want_result.ovf)
          begin
            if (mismatches < ReportLimit) begin
              $write("result %0d: want ch=%h valid=%b avail=%b ovf=%b, ",
                     results_seen, want_result.ch, want_result.rvalid, want_result.avail,
                     want_result.ovf);
              $display("got ch=%h valid=%b avail=%b ovf=%b",
                       seen_result.ch, seen_result.rvalid, seen_result.avail,
                       seen_result.ovf);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      // A single long hold-off lets the output back up until the block stops
      // taking input, while the sender keeps offering beats.
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        key_out.ready <= 1'b0;
      end else if (!hold_done && results_seen >= HoldOffAt) begin
        hold_done     <= 1'b1;
        hold_left     <= HoldOffLen - 1;
        key_out.ready <= 1'b0;
      end else begin
        key_out.ready <= !((idle_mode == IdleReceiver && chance(57)) ||
                           (idle_mode == IdleBoth && chance(22)));
      end
    end
  end

  // Watchdog: a block that stops moving beats ends the run.
  always @(posedge clk) begin
    if (!rst_n || (key_in.valid && key_in.ready) || (key_out.valid && key_out.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("no beat moved for %0d cycles", quiet_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    key_in.valid     = 1'b0;
    key_in.action    = ActScan;
    key_in.scan_code = 8'h00;
    key_out.ready    = 1'b0;
    pop_slot         = 0;
    push_slot        = 0;
    char_count       = 0;
    shift_down       = 1'b0;
    caps_toggled     = 1'b0;
    beats_taken      = 0;
    results_seen     = 0;
    mismatches       = 0;
    quiet_cycles     = 0;
    hold_left        = 0;
    hold_done        = 1'b0;
    drain_done       = 1'b0;
    build_stimulus();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Let the stream run dry, then collect what is still owed.
    while (key_stream.size() != 0 || key_in.valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/scta_pkg.sv
design/scta_in_if.sv
design/scta_out_if.sv
design/scta_keymap.sv
design/scta_fifo.sv
design/scancode_to_ascii_with_fifo.sv
sim/tb_scancode_to_ascii_with_fifo.sv
